### hw/rtl/tbrl_pkg.sv
// Shared constants, types and state codes of the token bucket rate limiter.
// Depends on nothing; used by tbrl_div and token_bucket_rate_limiter_core.
`timescale 1ns / 1ps
`default_nettype none

package tbrl_pkg;

	localparam int FLOW_COUNT = 256;
	localparam int FLOW_W     = $clog2(FLOW_COUNT);
	localparam int TIME_BITS  = 48;

	localparam int CAP_W   = 16;
	localparam int UNIT_W  = 12;
	localparam int PER_W   = 22;
	localparam int Q_W     = CAP_W;
	localparam int PROD_W  = CAP_W + PER_W;
	localparam int CNT_W   = $clog2(Q_W);

	localparam int IN_FLOW_W = 8;
	localparam int IN_TIME_W = 48;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [PER_W-1:0]  MS_PER_SECOND = PER_W'(1000);
	localparam logic [CAP_W-1:0]  CAP_RESET     = CAP_W'(10);
	localparam logic [UNIT_W-1:0] UNIT_RESET    = UNIT_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAPACITY = 1'b0,
		CFG_UNIT     = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] stamp;
		logic [CAP_W-1:0]     tokens;
	} entry_t;

endpackage

`default_nettype wire

### hw/rtl/token_bucket_rate_limiter_core.sv
// Top level of the per-flow token bucket policer: flow table, control and result register.
// Depends on tbrl_pkg and tbrl_div.
`timescale 1ns / 1ps
`default_nettype none

// Each request names a flow and carries a millisecond timestamp; the block answers with one
// result per request telling whether it passes and how many tokens the flow keeps. Flow
// state lives in a single-port table read into a register as the transfer is taken and
// written back when an admitted request finishes. Requests are handled one at a time: a
// flow seen for the first time goes from table read straight to write-back, any other
// request passes through table read, multiply, divider handoff, the 16 steps of the refill
// divider and write-back. A new request may be taken while an earlier result still waits
// on the output. Flow valid bits clear at reset, so no clearing pass is needed.
// Configuration is taken at any time and must only change while no request is in flight.
module token_bucket_rate_limiter_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tbrl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tbrl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [tbrl_pkg::IN_FLOW_W-1:0]  flow_index,
	input  wire logic [tbrl_pkg::IN_TIME_W-1:0]  timestamp_ms,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 admitted,
	output logic [tbrl_pkg::CAP_W-1:0]           tokens_left
);

	tbrl_pkg::state_t state_q, state_d;

	logic [tbrl_pkg::CAP_W-1:0]   cap_q;
	logic [tbrl_pkg::UNIT_W-1:0]  unit_q;

	tbrl_pkg::entry_t             mem [tbrl_pkg::FLOW_COUNT];
	logic [tbrl_pkg::FLOW_COUNT-1:0] valid_q;

	logic                         in_xfer;
	logic [tbrl_pkg::FLOW_W-1:0]  slot;
	logic [tbrl_pkg::FLOW_W-1:0]  slot_s1;
	logic [tbrl_pkg::TIME_BITS-1:0] now_s1;
	tbrl_pkg::entry_t             rd_s1;
	logic                         hit_s1;
	logic [tbrl_pkg::PER_W-1:0]   period_q;
	logic [tbrl_pkg::PER_W-1:0]   elapsed_q;
	logic [tbrl_pkg::PER_W-1:0]   elapsed_d;
	logic [tbrl_pkg::PER_W-1:0]   unit_fix;
	logic [tbrl_pkg::TIME_BITS-1:0] diff;

	logic                         div_start;
	logic                         div_done;
	logic [tbrl_pkg::Q_W-1:0]     div_quot;
	logic [tbrl_pkg::Q_W-1:0]     quot_q;
	logic [tbrl_pkg::PROD_W-1:0]  product;

	logic [tbrl_pkg::CAP_W:0]     fill_sum;
	logic [tbrl_pkg::CAP_W-1:0]   fill;
	logic [tbrl_pkg::CAP_W-1:0]   first_tokens;
	logic                         admit;
	logic                         fin_go;
	logic                         mem_we;
	tbrl_pkg::entry_t             wr_entry;

	logic                         out_valid_q;
	logic                         admitted_q;
	logic [tbrl_pkg::CAP_W-1:0]   tokens_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= tbrl_pkg::CAP_RESET;
			unit_q <= tbrl_pkg::UNIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tbrl_pkg::CFG_CAPACITY: cap_q  <= cfg_data;
				tbrl_pkg::CFG_UNIT:     unit_q <= cfg_data[tbrl_pkg::UNIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = state_q != tbrl_pkg::ST_IDLE;
	assign in_xfer  = in_valid && !in_stall;
	assign slot     = tbrl_pkg::FLOW_W'(flow_index);
	assign unit_fix = (unit_q == '0) ? tbrl_pkg::PER_W'(1) : tbrl_pkg::PER_W'(unit_q);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			slot_s1  <= slot;
			now_s1   <= tbrl_pkg::TIME_BITS'(timestamp_ms);
			rd_s1    <= mem[slot];
			hit_s1   <= valid_q[slot];
			period_q <= tbrl_pkg::PER_W'(unit_fix * tbrl_pkg::MS_PER_SECOND);
		end
		if (mem_we) begin
			mem[slot_s1] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (mem_we) begin
			valid_q[slot_s1] <= 1'b1;
		end
	end

	assign diff = now_s1 - rd_s1.stamp;

	always_comb begin
		if (now_s1 <= rd_s1.stamp) begin
			elapsed_d = '0;
		end else if (diff > tbrl_pkg::TIME_BITS'(period_q)) begin
			elapsed_d = period_q;
		end else begin
			elapsed_d = diff[tbrl_pkg::PER_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tbrl_pkg::ST_READ) begin
			elapsed_q <= elapsed_d;
		end
		if (div_done) begin
			quot_q <= div_quot;
		end
	end

	assign product = tbrl_pkg::PROD_W'(cap_q) * tbrl_pkg::PROD_W'(elapsed_q);

	tbrl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (period_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign fill_sum     = (tbrl_pkg::CAP_W + 1)'(rd_s1.tokens) + (tbrl_pkg::CAP_W + 1)'(quot_q);
	assign fill         = (fill_sum > (tbrl_pkg::CAP_W + 1)'(cap_q)) ? cap_q
	                      : fill_sum[tbrl_pkg::CAP_W-1:0];
	assign first_tokens = (cap_q == '0) ? '0 : cap_q - 1'b1;
	assign admit        = !hit_s1 || (fill != '0);
	assign fin_go       = (state_q == tbrl_pkg::ST_FIN) && (!out_valid_q || !out_stall);
	assign mem_we       = fin_go && admit;

	always_comb begin
		wr_entry.stamp  = now_s1;
		wr_entry.tokens = hit_s1 ? fill - 1'b1 : first_tokens;
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		unique case (state_q)
			tbrl_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = tbrl_pkg::ST_READ;
				end
			end
			tbrl_pkg::ST_READ: begin
				state_d = hit_s1 ? tbrl_pkg::ST_MUL : tbrl_pkg::ST_FIN;
			end
			tbrl_pkg::ST_MUL: begin
				div_start = 1'b1;
				state_d   = tbrl_pkg::ST_DIV;
			end
			tbrl_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = tbrl_pkg::ST_FIN;
				end
			end
			tbrl_pkg::ST_FIN: begin
				if (fin_go) begin
					state_d = tbrl_pkg::ST_IDLE;
				end
			end
			default: state_d = tbrl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tbrl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			admitted_q <= admit;
			tokens_q   <= admit ? wr_entry.tokens : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign admitted    = admitted_q;
	assign tokens_left = tokens_q;

	// A request is finished, and written back if admitted, before the next one is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while another is in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == tbrl_pkg::ST_DIV)
		else $error("divider finished outside the divide state");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !admitted |-> tokens_left == '0)
		else $error("refused request reports tokens");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && admitted |-> tokens_left < cap_q || tokens_left == '0)
		else $error("admitted request left a full bucket");

endmodule

`default_nettype wire

### hw/rtl/tbrl_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, for the refill amount.
// Depends on tbrl_pkg for the operand and quotient widths.
`timescale 1ns / 1ps
`default_nettype none

module tbrl_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [tbrl_pkg::PROD_W-1:0] dividend,
	input  wire logic [tbrl_pkg::PER_W-1:0]  divisor,
	output logic                             done,
	output logic [tbrl_pkg::Q_W-1:0]         quotient
);

	localparam int DSH_W = tbrl_pkg::PER_W + tbrl_pkg::Q_W - 1;

	logic [tbrl_pkg::PROD_W-1:0] rem_q;
	logic [DSH_W-1:0]            dsh_q;
	logic [tbrl_pkg::Q_W-1:0]    quot_q;
	logic [tbrl_pkg::CNT_W-1:0]  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic                        fits;
	logic [tbrl_pkg::PROD_W-1:0] dsh_ext;

	assign dsh_ext = tbrl_pkg::PROD_W'(dsh_q);
	assign fits    = rem_q >= dsh_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= tbrl_pkg::CNT_W'(tbrl_pkg::Q_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dsh_q  <= DSH_W'(divisor) << (tbrl_pkg::Q_W - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_ext;
			end
			quot_q <= {quot_q[tbrl_pkg::Q_W-2:0], fits};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

`default_nettype wire

### tb/sv/tbrl_admission_checker.sv
// Checker for the token bucket policer: keeps its own flow table and registers, predicts
// each admission verdict and compares it with the result transfers of the block.
// Depends on tbrl_pkg for widths, reset values and register indexes.
`timescale 1ns / 1ps

module tbrl_admission_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [tbrl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbrl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [tbrl_pkg::IN_FLOW_W-1:0]  flow_index,
	input  logic [tbrl_pkg::IN_TIME_W-1:0]  timestamp_ms,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic                            admitted,
	input  logic [tbrl_pkg::CAP_W-1:0]      tokens_left,
	output int                              mismatch_count,
	output int                              pending_count,
	output int                              admit_count,
	output int                              refuse_count
);
	import tbrl_pkg::*;

	typedef struct packed {
		logic             admitted;
		logic [CAP_W-1:0] tokens;
	} verdict_t;

	logic                 flow_seen   [FLOW_COUNT];
	logic [TIME_BITS-1:0] flow_stamp  [FLOW_COUNT];
	logic [CAP_W-1:0]     flow_tokens [FLOW_COUNT];
	logic [CAP_W-1:0]     capacity;
	logic [UNIT_W-1:0]    unit_secs;
	verdict_t             expected_verdicts [$];

	function automatic verdict_t police_request(logic [IN_FLOW_W-1:0] flow,
			logic [IN_TIME_W-1:0] stamp);
		verdict_t    v;
		int unsigned slot;
		logic [63:0] period;
		logic [63:0] elapsed;
		logic [63:0] fill;
		logic [63:0] cap_wide;
		slot     = int'(flow) % FLOW_COUNT;
		cap_wide = 64'(capacity);
		period   = 64'((unit_secs == '0) ? UNIT_W'(1) : unit_secs) * 64'(MS_PER_SECOND);
		if (!flow_seen[slot]) begin
			flow_seen[slot]   = 1'b1;
			flow_stamp[slot]  = stamp[TIME_BITS-1:0];
			flow_tokens[slot] = (capacity == '0) ? '0 : capacity - 1'b1;
			v.admitted = 1'b1;
			v.tokens   = flow_tokens[slot];
			return v;
		end
		elapsed = (stamp[TIME_BITS-1:0] > flow_stamp[slot]) ?
			64'(stamp[TIME_BITS-1:0] - flow_stamp[slot]) : 64'd0;
		if (elapsed > period)
			elapsed = period;
		fill = 64'(flow_tokens[slot]) + (cap_wide * elapsed) / period;
		if (fill > cap_wide)
			fill = cap_wide;
		if (fill != 64'd0) begin
			flow_stamp[slot]  = stamp[TIME_BITS-1:0];
			flow_tokens[slot] = CAP_W'(fill - 64'd1);
			v.admitted = 1'b1;
			v.tokens   = flow_tokens[slot];
		end else begin
			v.admitted = 1'b0;
			v.tokens   = '0;
		end
		return v;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
		$display("MISMATCH at %0t: %s expected %0d got %0d", $realtime, what, want, got);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			for (int i = 0; i < FLOW_COUNT; i++)
				flow_seen[i] = 1'b0;
			capacity  = CAP_RESET;
			unit_secs = UNIT_RESET;
			expected_verdicts.delete();
			mismatch_count = 0;
			pending_count  = 0;
			admit_count    = 0;
			refuse_count   = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index_t'(cfg_index))
					CFG_CAPACITY: capacity  = cfg_data[CAP_W-1:0];
					CFG_UNIT:     unit_secs = cfg_data[UNIT_W-1:0];
					default:      ;
				endcase
			end
			// A result transfer always belongs to an older request, so it is matched first.
			if (out_valid && !out_stall) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch("result with no request waiting, tokens_left",
						64'd0, 64'(tokens_left));
				end else begin
					want = expected_verdicts.pop_front();
					if (admitted !== want.admitted)
						report_mismatch("admitted", 64'(want.admitted), 64'(admitted));
					if (tokens_left !== want.tokens)
						report_mismatch("tokens_left", 64'(want.tokens), 64'(tokens_left));
					if (admitted === 1'b1)
						admit_count++;
					else
						refuse_count++;
				end
			end
			if (in_valid && !in_stall)
				expected_verdicts.push_back(police_request(flow_index, timestamp_ms));
			pending_count = expected_verdicts.size();
		end
	end

endmodule

### tb/sv/tb_token_bucket_rate_limiter_core.sv
// Testbench top of the token bucket policer: clock, reset, register writes, request and
// result traffic with random idling, and the verdict. Depends on tbrl_pkg, the block
// token_bucket_rate_limiter_core and the checker tbrl_admission_checker.
`timescale 1ns / 1ps

module tb_token_bucket_rate_limiter_core;
	import tbrl_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_ITEMS  = 75;
	localparam int PHASE_COUNT  = 10;
	localparam int TAIL_CYCLES  = 30;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [IN_FLOW_W-1:0]  flow_index;
	logic [IN_TIME_W-1:0]  timestamp_ms;
	logic                  out_valid;
	logic                  out_stall;
	logic                  admitted;
	logic [CAP_W-1:0]      tokens_left;

	int mismatch_count;
	int pending_count;
	int admit_count;
	int refuse_count;
	int cycle_count;
	int request_count;
	int setting_count;
	bit calm;

	logic [CAP_W-1:0]     cur_cap;
	logic [UNIT_W-1:0]    cur_unit;
	logic [IN_TIME_W-1:0] flow_clock [256];
	logic [IN_FLOW_W-1:0] flow_pool  [6];

	token_bucket_rate_limiter_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.flow_index   (flow_index),
		.timestamp_ms (timestamp_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.admitted     (admitted),
		.tokens_left  (tokens_left)
	);

	tbrl_admission_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.flow_index     (flow_index),
		.timestamp_ms   (timestamp_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.admitted       (admitted),
		.tokens_left    (tokens_left),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count),
		.admit_count    (admit_count),
		.refuse_count   (refuse_count)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, pending_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int wait_cycles;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			wait_cycles = calm ? 0 : $urandom_range(0, 8);
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Every task below starts and ends at a falling edge.
	task automatic write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		if (idx == CFG_CAPACITY)
			cur_cap = data[CAP_W-1:0];
		else
			cur_unit = data[UNIT_W-1:0];
		setting_count++;
	endtask

	task automatic send_request(logic [IN_FLOW_W-1:0] flow, logic [IN_TIME_W-1:0] stamp);
		int gap;
		cfg_valid <= 1'b0;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		flow_index   <= flow;
		timestamp_ms <= stamp;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		flow_clock[flow] = stamp;
		request_count++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
	endtask

	task automatic random_request();
		logic [IN_FLOW_W-1:0] flow;
		logic [IN_TIME_W-1:0] stamp;
		logic [31:0]          period;
		logic [31:0]          per_token;
		flow = ($urandom_range(0, 9) < 7) ? flow_pool[$urandom_range(0, 5)] :
			IN_FLOW_W'($urandom_range(0, 255));
		period    = ((cur_unit == '0) ? 32'd1 : 32'(cur_unit)) * 32'd1000;
		per_token = period / ((cur_cap == '0) ? 32'd1 : 32'(cur_cap));
		stamp     = flow_clock[flow];
		case ($urandom_range(0, 9))
			0:             ;
			1, 2, 3, 4, 5: stamp = stamp + IN_TIME_W'($urandom_range(0, per_token * 2 + 1));
			6, 7:          stamp = stamp + IN_TIME_W'($urandom_range(0, period * 2));
			8:             stamp = stamp - IN_TIME_W'($urandom_range(1, 2000));
			default:       stamp = {16'($urandom), 32'($urandom)};
		endcase
		send_request(flow, stamp);
	endtask

	task automatic random_phase();
		logic [CAP_W-1:0]      cap_value;
		logic [UNIT_W-1:0]     unit_value;
		logic [CFG_DATA_W-1:0] unit_data;
		case ($urandom_range(0, 9))
			0:       cap_value = '0;
			1:       cap_value = 16'd1;
			2, 3:    cap_value = CAP_W'($urandom_range(2, 20));
			4, 5:    cap_value = CAP_W'($urandom_range(21, 1000));
			6:       cap_value = 16'hFFFF;
			default: cap_value = CAP_W'($urandom_range(1, 65535));
		endcase
		case ($urandom_range(0, 11))
			0:          unit_value = '0;
			1:          unit_value = 12'd1;
			2, 3, 4:    unit_value = UNIT_W'($urandom_range(1, 5));
			5:          unit_value = 12'd3600;
			6:          unit_value = 12'hFFF;
			default:    unit_value = UNIT_W'($urandom_range(1, 4095));
		endcase
		unit_data = {4'($urandom), unit_value};
		drain_results();
		if ($urandom_range(0, 1)) begin
			write_register(CFG_CAPACITY, cap_value);
			write_register(CFG_UNIT, unit_data);
		end else begin
			write_register(CFG_UNIT, unit_data);
			write_register(CFG_CAPACITY, cap_value);
		end
		foreach (flow_pool[i])
			flow_pool[i] = IN_FLOW_W'($urandom_range(0, 255));
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if (n % 20 == 0)
				calm = ($urandom_range(0, 3) == 0);
			random_request();
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		flow_index   = '0;
		timestamp_ms = '0;
		calm         = 1'b0;
		cycle_count  = 0;
		request_count = 0;
		setting_count = 0;
		cur_cap      = CAP_RESET;
		cur_unit     = UNIT_RESET;
		foreach (flow_clock[i])
			flow_clock[i] = {16'($urandom), 32'($urandom)};
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: first sighting, zero elapsed time, partial refill, backward time,
		// largest timestamp and a refill clamped to one period.
		send_request(8'd0, 48'd0);
		send_request(8'd0, 48'd0);
		send_request(8'd0, 48'd50);
		send_request(8'd0, 48'd150);
		send_request(8'd255, 48'hFFFF_FFFF_FFFF);
		send_request(8'd255, 48'd0);
		send_request(8'd0, 48'd100000);

		// Zero unit setting, which counts as one, with a tiny bucket: the bucket runs dry and a request is refused.
		drain_results();
		write_register(CFG_CAPACITY, 16'd2);
		write_register(CFG_UNIT, 16'h0000);
		send_request(8'd1, 48'd7);
		send_request(8'd1, 48'd7);
		send_request(8'd1, 48'd7);
		send_request(8'd1, 48'd507);
		send_request(8'd2, 48'hAAAA_AAAA_AAAA);
		send_request(8'd2, 48'h5555_5555_5555);

		// Zero capacity and the longest period, with the upper data bits set.
		drain_results();
		write_register(CFG_CAPACITY, 16'd0);
		write_register(CFG_UNIT, 16'hFFFF);
		send_request(8'd3, 48'h5555_5555_5555);
		send_request(8'd3, 48'h5555_5555_5555 + 48'd4095000);
		send_request(8'd0, 48'h8000_0000_0000);

		// Largest capacity, then a lower one that caps the stored counts.
		drain_results();
		write_register(CFG_CAPACITY, 16'hFFFF);
		write_register(CFG_UNIT, 16'h0001);
		send_request(8'd4, 48'h1000);
		send_request(8'd4, 48'h1000 + 48'd1000);
		send_request(8'd4, 48'h1000 + 48'd1001);
		drain_results();
		write_register(CFG_CAPACITY, 16'd3);
		send_request(8'd4, 48'h1000 + 48'd1001);
		send_request(8'd255, 48'hFFFF_FFFF_FFFF);

		repeat (PHASE_COUNT)
			random_phase();

		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Sent %0d requests under %0d register writes; %0d admitted, %0d refused.",
			request_count, setting_count, admit_count, refuse_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### token_bucket_rate_limiter_core.f
hw/rtl/tbrl_pkg.sv
hw/rtl/tbrl_div.sv
hw/rtl/token_bucket_rate_limiter_core.sv
tb/sv/tbrl_admission_checker.sv
tb/sv/tb_token_bucket_rate_limiter_core.sv
